[design/lanczos_kernel_weight_assert.svh]
// Assertion macros for the kernel weight top-level design file.
`ifndef LANCZOS_KERNEL_WEIGHT_ASSERT_SVH
`define LANCZOS_KERNEL_WEIGHT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define LKW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define LKW_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define LKW_ASSERT(lbl, prop, msg)
`define LKW_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

[design/lkw_pkg.sv]
// Constants and tables shared by the kernel weight design.
package lkw_pkg;
  localparam int FRAC_BITS_DEF    = 16;
  localparam int CORDIC_STEPS_DEF = 18;
  localparam int TAU_W            = 16;
  localparam int TAU_FRAC         = 12;
  localparam logic [TAU_W-1:0] TAU_RESET = 16'd12288;
  localparam int ANG_BITS         = 30;
  localparam logic [31:0] PI_Q30  = 32'd3373259426;
  localparam logic signed [31:0] GAIN_Q30 = 32'sd652032874;
  localparam int TINY_NUM         = 1000000;
  localparam int TINY_SCALE       = 10;
  localparam int ATAN_N           = 30;

  // Arctangent of 2^-i in Q30 radians.
  localparam logic [31:0] ATAN_Q30 [ATAN_N] = '{
    32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159, 32'd67021687,
    32'd33543516,  32'd16775851,  32'd8388437,   32'd4194283,   32'd2097149,
    32'd1048576,   32'd524288,    32'd262144,    32'd131072,    32'd65536,
    32'd32768,     32'd16384,     32'd8192,      32'd4096,      32'd2048,
    32'd1024,      32'd512,       32'd256,       32'd128,       32'd64,
    32'd32,        32'd16,        32'd8,         32'd4,         32'd2
  };
endpackage

[design/lkw_offset_if.sv]
// Input channel carrying one signed offset word.
interface lkw_offset_if #(
  parameter int FRAC_BITS = lkw_pkg::FRAC_BITS_DEF
) ();
  logic                        valid;
  logic                        ready;
  logic signed [FRAC_BITS+3:0] offset;
  modport source (output valid, output offset, input ready);
  modport sink   (input valid, input offset, output ready);
endinterface

[design/lkw_weight_if.sv]
// Output channel carrying one signed weight word.
interface lkw_weight_if #(
  parameter int FRAC_BITS = lkw_pkg::FRAC_BITS_DEF
) ();
  logic                        valid;
  logic                        ready;
  logic signed [FRAC_BITS+1:0] weight;
  modport source (output valid, output weight, input ready);
  modport sink   (input valid, input weight, output ready);
endinterface

[design/lkw_sin.sv]
// Pipelined CORDIC sine of a half-turn angle.
module lkw_sin #(
  parameter int FRAC_BITS    = lkw_pkg::FRAC_BITS_DEF,
  parameter int CORDIC_STEPS = lkw_pkg::CORDIC_STEPS_DEF
) (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [FRAC_BITS:0]          h_i,
  output logic signed [FRAC_BITS+1:0] s_o
);
  import lkw_pkg::*;

  localparam int F = FRAC_BITS;
  localparam int S = CORDIC_STEPS;
  localparam logic [F:0] One = {1'b1, {F{1'b0}}};
  localparam logic signed [31:0] OneS = 32'sd1 <<< F;
  localparam logic signed [31:0] RndS = 32'sd1 <<< (ANG_BITS - F - 1);

  logic [F-1:0]   hl;
  logic [F-1:0]   hf;
  logic [F+31:0]  zp;

  logic signed [31:0] x_q [S+1];
  logic signed [31:0] y_q [S+1];
  logic signed [32:0] z_q [S+1];
  logic               neg_q [S+1];
  logic signed [F+1:0] s_q;

  // The upper half-turn flips the sign; the second quadrant mirrors the first.
  assign hl = h_i[F-1:0];
  always_comb begin
    if ({1'b0, hl, 1'b0} > {1'b0, One}) begin
      hf = F'(One - {1'b0, hl});
    end else begin
      hf = hl;
    end
  end
  assign zp = (F+32)'(hf) * (F+32)'(PI_Q30) + ((F+32)'(1) << (F - 1));

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]   <= GAIN_Q30;
      y_q[0]   <= 32'sd0;
      z_q[0]   <= $signed(33'(zp >> F));
      neg_q[0] <= h_i[F];
    end
  end

  for (genvar i = 0; i < S; i++) begin : g_step
    localparam logic signed [32:0] At = $signed({1'b0, ATAN_Q30[i]});
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        neg_q[i+1] <= neg_q[i];
        if (!z_q[i][32]) begin
          x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] - At;
        end else begin
          x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] + At;
        end
      end
    end
  end

  logic signed [31:0] r;
  logic signed [31:0] rc;
  assign r = (y_q[S] + RndS) >>> (ANG_BITS - F);
  always_comb begin
    if (r < 0) begin
      rc = 32'sd0;
    end else if (r > OneS) begin
      rc = OneS;
    end else begin
      rc = r;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s_q <= neg_q[S] ? -(F+2)'(rc) : (F+2)'(rc);
    end
  end
  assign s_o = s_q;
endmodule

[design/lkw_div.sv]
// Pipelined restoring divider, one quotient bit per stage, rounded and clamped.
module lkw_div #(
  parameter int FRAC_BITS = lkw_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic signed [FRAC_BITS+1:0] num_i,
  input  logic [FRAC_BITS+5:0]        den_i,
  output logic signed [FRAC_BITS+1:0] q_o
);
  localparam int F   = FRAC_BITS;
  localparam int NW  = 2 * F + 2;
  localparam int DDW = F + 7;
  localparam int NSt = F + 2;
  localparam logic [F:0] One = {1'b1, {F{1'b0}}};

  logic [F:0]     mag;
  logic [NW-1:0]  n0;
  logic [DDW-1:0] d0;

  logic [NW-1:0]  r_q    [NSt];
  logic [F:0]     q_q    [NSt];
  logic [DDW-1:0] d_q    [NSt];
  logic           sat_q  [NSt];
  logic           neg_q  [NSt];
  logic           zero_q [NSt];
  logic signed [F+1:0] res_q;

  // Adding the divisor before halving gives round half away from zero.
  assign mag = num_i[F+1] ? (F+1)'(-num_i) : (F+1)'(num_i);
  assign n0  = (NW'(mag) << (F + 1)) + NW'(den_i);
  assign d0  = {den_i, 1'b0};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q[0]    <= n0;
      q_q[0]    <= '0;
      d_q[0]    <= d0;
      sat_q[0]  <= (n0 >> (F + 1)) >= NW'(d0);
      neg_q[0]  <= num_i[F+1];
      zero_q[0] <= (den_i == '0);
    end
  end

  for (genvar j = 0; j <= F; j++) begin : g_bit
    localparam int K = F - j;
    logic ge;
    assign ge = (r_q[j] >> K) >= NW'(d_q[j]);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[j+1]    <= ge ? r_q[j] - (NW'(d_q[j]) << K) : r_q[j];
        q_q[j+1]    <= q_q[j] | ((F+1)'(ge) << K);
        d_q[j+1]    <= d_q[j];
        sat_q[j+1]  <= sat_q[j];
        neg_q[j+1]  <= neg_q[j];
        zero_q[j+1] <= zero_q[j];
      end
    end
  end

  logic [F:0] qm;
  assign qm = (sat_q[NSt-1] || (q_q[NSt-1] > One)) ? One : q_q[NSt-1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (zero_q[NSt-1]) begin
        res_q <= (F+2)'(One);
      end else begin
        res_q <= neg_q[NSt-1] ? -(F+2)'(qm) : (F+2)'(qm);
      end
    end
  end
  assign q_o = res_q;
endmodule

[design/lanczos_kernel_weight.sv]
// Top level of the Lanczos windowed-sinc weight pipeline.
//
//   Channel   Dir  Handshake          Word
//   in_i      in   valid / ready      offset, signed Q3.F
//   out_o     out  valid / ready      weight, signed Q1.F
//   cfg       in   cfg_we_i           window tau, unsigned Q4.12
//
// One word enters per cycle while the output side takes words. Most of the
// pipeline depth lies in the CORDIC rotation stages and the one-bit-per-stage
// dividers that follow them. Reset clears every valid bit and loads tau with
// 3.0; no clearing pass runs. A stall at the output freezes the whole pipeline
// in place, so no word is lost or repeated, and the input is accepted again in
// the cycle it clears.
module lanczos_kernel_weight #(
  parameter int FRAC_BITS    = lkw_pkg::FRAC_BITS_DEF,
  parameter int CORDIC_STEPS = lkw_pkg::CORDIC_STEPS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [lkw_pkg::TAU_W-1:0]  cfg_wdata_i,
  lkw_offset_if.sink                 in_i,
  lkw_weight_if.source               out_o
);
  import lkw_pkg::*;
  `include "lanczos_kernel_weight_assert.svh"

  localparam int F       = FRAC_BITS;
  localparam int OffW    = F + 4;
  localparam int AW      = F + 1;
  localparam int TW      = F + 5;
  localparam int DW      = F + 6;
  localparam int SW      = F + 2;
  localparam int LatSin  = CORDIC_STEPS + 2;
  localparam int LatDiv  = F + 3;
  localparam int LineLen = LatSin + LatDiv;
  localparam int TW_PROD = AW + TAU_W + 1;
  localparam logic [AW-1:0] One = {1'b1, {F{1'b0}}};
  localparam logic signed [SW-1:0] SOne    = $signed(SW'(One));
  localparam logic signed [SW-1:0] SNegOne = -SOne;

  typedef struct packed {
    logic          v;
    logic          tiny;
    logic          big;
    logic [DW-1:0] den1;
    logic [DW-1:0] den2;
  } side_t;

  logic en;
  logic out_v_q;
  logic signed [SW-1:0] weight_q;
  logic [TAU_W-1:0] tau_q;

  // The whole pipeline moves together whenever the output register can move.
  assign en         = !out_v_q || out_o.ready;
  assign in_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tau_q <= TAU_RESET;
    end else if (cfg_we_i) begin
      tau_q <= cfg_wdata_i;
    end
  end

  // Stage A: absolute value and the two range checks.
  logic [OffW-1:0]    abs_in;
  logic [OffW+19:0]   tiny_prod;
  logic               va_q, tiny_a_q, big_a_q;
  logic [AW-1:0]      a_a_q;

  assign abs_in    = in_i.offset[OffW-1] ? OffW'(-in_i.offset) : OffW'(in_i.offset);
  assign tiny_prod = (OffW+20)'(abs_in) * (OffW+20)'(TINY_NUM);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else if (en) begin
      va_q <= in_i.valid;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      tiny_a_q <= tiny_prod < ((OffW+20)'(TINY_SCALE) << F);
      big_a_q  <= abs_in > OffW'(One);
      a_a_q    <= abs_in[AW-1:0];
    end
  end

  // Stage B: window argument a*tau and the first denominator pi*a.
  logic [TW_PROD-1:0] at_prod;
  logic [AW+32:0]     ap_prod;
  logic               vb_q, tiny_b_q, big_b_q;
  logic [AW-1:0]      a_b_q;
  logic [TW-1:0]      t_b_q;
  logic [DW-1:0]      den1_b_q;

  assign at_prod = TW_PROD'(a_a_q) * TW_PROD'(tau_q) + (TW_PROD'(1) << (TAU_FRAC - 1));
  assign ap_prod = (AW+33)'(a_a_q) * (AW+33)'(PI_Q30) + ((AW+33)'(1) << (ANG_BITS - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= 1'b0;
    end else if (en) begin
      vb_q <= va_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      tiny_b_q <= tiny_a_q;
      big_b_q  <= big_a_q;
      a_b_q    <= a_a_q;
      t_b_q    <= TW'(at_prod >> TAU_FRAC);
      den1_b_q <= DW'(ap_prod >> ANG_BITS);
    end
  end

  // Side line: flags and denominators ride beside the sine and divide units.
  logic [TW+32:0] tp_prod;
  side_t          line_d;
  side_t          line_q [LineLen];

  assign tp_prod = (TW+33)'(t_b_q) * (TW+33)'(PI_Q30) + ((TW+33)'(1) << (ANG_BITS - 1));
  assign line_d  = '{v: vb_q, tiny: tiny_b_q, big: big_b_q, den1: den1_b_q,
                     den2: DW'(tp_prod >> ANG_BITS)};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LineLen; i++) begin
        line_q[i].v <= 1'b0;
      end
    end else if (en) begin
      line_q[0] <= line_d;
      for (int i = 1; i < LineLen; i++) begin
        line_q[i] <= line_q[i-1];
      end
    end
  end

  // Sines of pi*a and pi*a*tau, both taken in half-turns.
  logic signed [SW-1:0] s_a, s_t;
  logic signed [SW-1:0] q1, q2;

  lkw_sin #(.FRAC_BITS(F), .CORDIC_STEPS(CORDIC_STEPS)) u_sin_a (
    .clk_i (clk_i), .en_i (en), .h_i (a_b_q), .s_o (s_a)
  );
  lkw_sin #(.FRAC_BITS(F), .CORDIC_STEPS(CORDIC_STEPS)) u_sin_t (
    .clk_i (clk_i), .en_i (en), .h_i (t_b_q[F:0]), .s_o (s_t)
  );

  // A zero denominator makes the divider return 1.0, which covers a vanishing
  // window argument.
  lkw_div #(.FRAC_BITS(F)) u_div_a (
    .clk_i (clk_i), .en_i (en), .num_i (s_a), .den_i (line_q[LatSin-1].den1), .q_o (q1)
  );
  lkw_div #(.FRAC_BITS(F)) u_div_t (
    .clk_i (clk_i), .en_i (en), .num_i (s_t), .den_i (line_q[LatSin-1].den2), .q_o (q2)
  );

  // Product of the two sinc terms as sign and magnitude.
  logic [AW-1:0]    m1, m2;
  logic             vp_q, tiny_p_q, big_p_q, neg_p_q;
  logic [2*AW-1:0]  magp_q;

  assign m1 = q1[SW-1] ? AW'(-q1) : AW'(q1);
  assign m2 = q2[SW-1] ? AW'(-q2) : AW'(q2);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vp_q <= 1'b0;
    end else if (en) begin
      vp_q <= line_q[LineLen-1].v;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      tiny_p_q <= line_q[LineLen-1].tiny;
      big_p_q  <= line_q[LineLen-1].big;
      neg_p_q  <= q1[SW-1] ^ q2[SW-1];
      magp_q   <= (2*AW)'(m1) * (2*AW)'(m2);
    end
  end

  // Final rounding, clamp to 1.0 and the two range overrides.
  logic [2*AW:0]  rnd;
  logic [AW-1:0]  rc;
  assign rnd = ((2*AW+1)'(magp_q) + ((2*AW+1)'(1) << (F - 1))) >> F;
  assign rc  = (rnd > (2*AW+1)'(One)) ? One : AW'(rnd);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= vp_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      if (tiny_p_q) begin
        weight_q <= SOne;
      end else if (big_p_q) begin
        weight_q <= '0;
      end else begin
        weight_q <= neg_p_q ? -SW'(rc) : SW'(rc);
      end
    end
  end

  assign out_o.valid  = out_v_q;
  assign out_o.weight = weight_q;

  `LKW_ASSERT(a_weight_range, out_v_q |-> (weight_q <= SOne && weight_q >= SNegOne), "weight beyond one")
  `LKW_ASSERT(a_term_range, line_q[LineLen-1].v |-> (q1 <= SOne && q1 >= SNegOne && q2 <= SOne && q2 >= SNegOne), "sinc term beyond one")
  `LKW_ASSERT(a_stall_freeze, (out_v_q && !out_o.ready) |=> ($stable(line_q[0]) && $stable(vp_q)), "pipeline moved during stall")
endmodule
